### hdl/pfc_pkg.sv
`default_nettype none

package pfc_pkg;

    localparam int KEY_CHARS_DEF = 16;
    localparam int SIDE          = 5;
    localparam int GRID_CELLS    = 25;
    localparam int ALPHA         = 26;
    localparam int MAX_RES       = 4;
    localparam int PUSH_W        = $clog2(MAX_RES + 1);
    localparam int FIFO_DEPTH    = 8;

    typedef logic [4:0] letter_t;
    typedef logic [4:0] place_t;
    typedef logic [2:0] coord_t;

    localparam letter_t LETTER_I = 5'd8;
    localparam letter_t LETTER_J = 5'd9;
    localparam letter_t LETTER_X = 5'd23;

    localparam logic [7:0] ASCII_UP_A = 8'h41;
    localparam logic [7:0] ASCII_UP_Z = 8'h5A;
    localparam logic [7:0] ASCII_LO_A = 8'h61;
    localparam logic [7:0] ASCII_LO_Z = 8'h7A;
    localparam logic [6:0] CHAR_BASE  = 7'h41;

    localparam logic [1:0] REG_KEY_LOW  = 2'd0;
    localparam logic [1:0] REG_KEY_HIGH = 2'd1;
    localparam logic [1:0] REG_KEY_LEN  = 2'd2;

    typedef struct packed {
        logic    valid;
        letter_t idx;
    } letter_dec_t;

    // One write into both lookup memories: grid[pos] = letter, place[letter] = pos.
    typedef struct packed {
        logic    we;
        place_t  pos;
        letter_t letter;
    } grid_wr_t;

    typedef struct packed {
        logic [6:0] cipher_char;
        logic       has_char;
        logic       message_end;
    } result_t;

    function automatic letter_dec_t decode_letter(input logic [7:0] b);
        letter_dec_t d;
        d.valid = 1'b0;
        d.idx   = '0;
        if (b >= ASCII_UP_A && b <= ASCII_UP_Z)
        begin
            d.valid = 1'b1;
            d.idx   = 5'(b - ASCII_UP_A);
        end
        else if (b >= ASCII_LO_A && b <= ASCII_LO_Z)
        begin
            d.valid = 1'b1;
            d.idx   = 5'(b - ASCII_LO_A);
        end
        return d;
    endfunction

    // J shares the grid place of I.
    function automatic letter_t place_key(input letter_t l);
        return (l == LETTER_J) ? LETTER_I : l;
    endfunction

    function automatic coord_t place_row(input place_t p);
        coord_t r;
        if (p >= 5'(4 * SIDE))
            r = 3'd4;
        else if (p >= 5'(3 * SIDE))
            r = 3'd3;
        else if (p >= 5'(2 * SIDE))
            r = 3'd2;
        else if (p >= 5'(SIDE))
            r = 3'd1;
        else
            r = 3'd0;
        return r;
    endfunction

    function automatic coord_t place_col(input place_t p);
        return 3'(p - 5'(place_row(p)) * 5'(SIDE));
    endfunction

    function automatic coord_t coord_inc(input coord_t c);
        return (c == 3'(SIDE - 1)) ? 3'd0 : c + 3'd1;
    endfunction

    function automatic place_t cell_at(input coord_t r, input coord_t c);
        return 5'(5'(r) * 5'(SIDE) + 5'(c));
    endfunction

endpackage

`default_nettype wire

### hdl/pfc_dpram.sv
`default_nettype none

module pfc_dpram #(
    parameter int DEPTH = 25,
    parameter int WIDTH = 5
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

`default_nettype wire

### hdl/pfc_key_sched.sv
`default_nettype none

module pfc_key_sched import pfc_pkg::*; #(
    parameter int KEY_CHARS = KEY_CHARS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] key_low,
    input  wire logic [63:0] key_high,
    input  wire logic [4:0]  key_length,
    output grid_wr_t         wr,
    output logic             busy
);

    localparam int STEPS = KEY_CHARS + ALPHA;
    localparam int SW    = $clog2(STEPS);
    localparam int CW    = (SW > 5) ? SW : 5;
    localparam logic [SW-1:0] LAST_STEP = SW'(STEPS - 1);
    localparam logic [SW-1:0] KEY_STEPS = SW'(KEY_CHARS);

    typedef enum logic [1:0] {
        KS_IDLE = 2'b01,
        KS_RUN  = 2'b10
    } ks_state_t;

    ks_state_t      state_reg, state_next;
    logic [SW-1:0]  step_reg, step_next;
    place_t         pos_reg, pos_next;
    logic [ALPHA-1:0] used_reg, used_next;

    logic [127:0]   key_all;
    logic [4:0]     klen;
    logic [7:0]     key_byte;
    letter_dec_t    key_dec;
    logic           cand_v;
    letter_t        cand;
    logic           take;

    assign key_all  = {key_high, key_low};
    assign klen     = (key_length > 5'(KEY_CHARS)) ? 5'(KEY_CHARS) : key_length;
    assign key_byte = key_all[{step_reg[3:0], 3'b000} +: 8];
    assign key_dec  = decode_letter(key_byte);

    // Key characters come first, then the whole alphabet as filler.
    always_comb
    begin
        if (step_reg < KEY_STEPS)
        begin
            cand_v = key_dec.valid && (CW'(step_reg) < CW'(klen));
            cand   = place_key(key_dec.idx);
        end
        else
        begin
            cand_v = 1'b1;
            cand   = 5'(step_reg - KEY_STEPS);
        end
    end

    assign take = (state_reg == KS_RUN) && cand_v && !used_reg[cand]
                  && (pos_reg < 5'(GRID_CELLS));
    assign wr   = '{we: take, pos: pos_reg, letter: cand};
    assign busy = (state_reg == KS_RUN);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        pos_next   = pos_reg;
        used_next  = used_reg;
        case (state_reg)
            KS_IDLE:
            begin
                if (start)
                begin
                    state_next = KS_RUN;
                    step_next  = '0;
                    pos_next   = '0;
                    used_next  = ALPHA'(1) << LETTER_J;
                end
            end
            KS_RUN:
            begin
                if (take)
                begin
                    used_next[cand] = 1'b1;
                    pos_next        = pos_reg + 5'd1;
                end
                step_next = step_reg + SW'(1);
                if (step_reg == LAST_STEP)
                begin
                    state_next = KS_IDLE;
                end
            end
            default:
            begin
                state_next = KS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= KS_IDLE;
            step_reg  <= '0;
            pos_reg   <= '0;
            used_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            pos_reg   <= pos_next;
            used_reg  <= used_next;
        end
    end

endmodule

`default_nettype wire

### hdl/pfc_out_fifo.sv
`default_nettype none

module pfc_out_fifo import pfc_pkg::*; #(
    parameter int DEPTH = FIFO_DEPTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [PUSH_W-1:0] push_cnt,
    input  wire result_t           push_data [MAX_RES],
    output logic                   room,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic      [6:0]        cipher_char,
    output logic                   has_char,
    output logic                   message_end_res
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    result_t        mem [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           pop;
    result_t        head;

    assign pop       = out_valid && !out_stall;
    assign out_valid = (cnt_reg != '0);
    assign head      = mem[rd_ptr_reg];
    assign cipher_char     = head.cipher_char;
    assign has_char        = head.has_char;
    assign message_end_res = head.message_end;

    // Room for a whole item's worth of words, so the pipeline never backs up mid-item.
    assign room     = (cnt_reg <= CW'(DEPTH - MAX_RES));
    assign cnt_next = cnt_reg + CW'(push_cnt) - CW'(pop);

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_RES; k++)
        begin
            if (PUSH_W'(k) < push_cnt)
            begin
                mem[AW'(wr_ptr_reg + AW'(k))] <= push_data[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= AW'(wr_ptr_reg + AW'(push_cnt));
            rd_ptr_reg <= AW'(rd_ptr_reg + AW'(pop));
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

### hdl/playfair_digraph_cipher_unit.sv
// A word accepted at the input passes the input register, the place memories, the grid
// memories and the output FIFO before its first result word leaves. Throughput: one
// input word per cycle while in_stall is low; results leave the output FIFO one word
// per cycle while out_stall is low. Reset: control state clears; the key schedule then
// steps through the key characters and the alphabet to fill the grid memories, and
// reruns after a key write before the next message; the input stalls during a sweep.
`default_nettype none

module playfair_digraph_cipher_unit import pfc_pkg::*; #(
    parameter int KEY_CHARS = KEY_CHARS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  text_char,
    input  wire logic        message_end,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic      [6:0]  cipher_char,
    output logic             has_char,
    output logic             message_end_res
);

    logic [63:0] key_low_reg, key_high_reg;
    logic [4:0]  key_len_reg;
    logic        dirty_reg;

    grid_wr_t    ks_wr;
    logic        ks_busy;
    logic        build_go;

    logic        adv;
    logic        accept;

    logic        s1_v_reg;
    logic [7:0]  s1_char_reg;
    logic        s1_end_reg;

    letter_t     held_reg, prev_reg;
    logic        held_v_reg, prev_v_reg;

    letter_dec_t s1_dec;
    logic        s1_dup;
    logic        hv_c;
    letter_t     hl_c;
    logic [1:0]  np_c;
    letter_t     pa_c [2];
    letter_t     pb_c [2];

    logic        s2_v_reg, s2_end_reg;
    logic [1:0]  s2_np_reg;
    place_t      pl_a [2];
    place_t      pl_b [2];
    coord_t      ra [2];
    coord_t      ca [2];
    coord_t      rb [2];
    coord_t      cb [2];
    place_t      qa [2];
    place_t      qb [2];

    logic        s3_v_reg, s3_end_reg;
    logic [1:0]  s3_np_reg;
    letter_t     gl [MAX_RES];
    result_t     res [MAX_RES];
    logic [PUSH_W-1:0] res_cnt;
    logic [PUSH_W-1:0] push_cnt;

    // Configuration registers; a write marks the grid stale.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            key_len_reg  <= '0;
            dirty_reg    <= 1'b1;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_KEY_LOW:  key_low_reg  <= cfg_data;
                    REG_KEY_HIGH: key_high_reg <= cfg_data;
                    REG_KEY_LEN:  key_len_reg  <= cfg_data[4:0];
                    default: ;
                endcase
            end
            if (cfg_we)
                dirty_reg <= 1'b1;
            else if (build_go)
                dirty_reg <= 1'b0;
        end
    end

    // The grid is only rebuilt before the first letter of a message, with nothing in flight.
    assign build_go = dirty_reg && !ks_busy && !prev_v_reg
                      && !s1_v_reg && !s2_v_reg && !s3_v_reg;

    pfc_key_sched #(
        .KEY_CHARS (KEY_CHARS)
    ) u_key_sched (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (build_go),
        .key_low    (key_low_reg),
        .key_high   (key_high_reg),
        .key_length (key_len_reg),
        .wr         (ks_wr),
        .busy       (ks_busy)
    );

    assign in_stall = !adv || ((dirty_reg || ks_busy) && (!prev_v_reg || s1_v_reg));
    assign accept   = in_valid && !in_stall;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_v_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_char_reg <= text_char;
            s1_end_reg  <= message_end;
        end
    end

    // Pair forming: an optional doubling X, the letter itself, then the end pad.
    always_comb
    begin
        s1_dec  = decode_letter(s1_char_reg);
        s1_dup  = s1_dec.valid && prev_v_reg && (prev_reg == s1_dec.idx);
        hv_c    = held_v_reg;
        hl_c    = held_reg;
        np_c    = '0;
        pa_c[0] = '0;
        pa_c[1] = '0;
        pb_c[0] = '0;
        pb_c[1] = '0;
        if (s1_dup)
        begin
            if (hv_c)
            begin
                pa_c[0] = hl_c;
                pb_c[0] = LETTER_X;
                np_c    = 2'd1;
                hv_c    = 1'b0;
                hl_c    = '0;
            end
            else
            begin
                hl_c = LETTER_X;
                hv_c = 1'b1;
            end
        end
        if (s1_dec.valid)
        begin
            if (hv_c)
            begin
                pa_c[np_c[0]] = hl_c;
                pb_c[np_c[0]] = s1_dec.idx;
                np_c          = np_c + 2'd1;
                hv_c          = 1'b0;
                hl_c          = '0;
            end
            else
            begin
                hl_c = s1_dec.idx;
                hv_c = 1'b1;
            end
        end
        if (s1_end_reg && hv_c)
        begin
            pa_c[np_c[0]] = hl_c;
            pb_c[np_c[0]] = LETTER_X;
            np_c          = np_c + 2'd1;
            hv_c          = 1'b0;
            hl_c          = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg   <= '0;
            held_v_reg <= 1'b0;
            prev_reg   <= '0;
            prev_v_reg <= 1'b0;
            s2_v_reg   <= 1'b0;
            s2_np_reg  <= '0;
            s2_end_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_v_reg   <= s1_v_reg;
            s2_np_reg  <= np_c;
            s2_end_reg <= s1_end_reg;
            if (s1_v_reg)
            begin
                if (s1_end_reg)
                begin
                    held_reg   <= '0;
                    held_v_reg <= 1'b0;
                    prev_reg   <= '0;
                    prev_v_reg <= 1'b0;
                end
                else
                begin
                    held_reg   <= hl_c;
                    held_v_reg <= hv_c;
                    if (s1_dec.valid)
                    begin
                        prev_reg   <= s1_dec.idx;
                        prev_v_reg <= 1'b1;
                    end
                end
            end
        end
    end

    // Letter to grid place, one memory per pair.
    pfc_dpram #(
        .DEPTH (ALPHA),
        .WIDTH ($bits(place_t))
    ) u_place_p0 (
        .clk     (clk),
        .we      (ks_wr.we),
        .waddr   (ks_wr.letter),
        .wdata   (ks_wr.pos),
        .re      (adv),
        .raddr_a (place_key(pa_c[0])),
        .raddr_b (place_key(pb_c[0])),
        .rdata_a (pl_a[0]),
        .rdata_b (pl_b[0])
    );

    pfc_dpram #(
        .DEPTH (ALPHA),
        .WIDTH ($bits(place_t))
    ) u_place_p1 (
        .clk     (clk),
        .we      (ks_wr.we),
        .waddr   (ks_wr.letter),
        .wdata   (ks_wr.pos),
        .re      (adv),
        .raddr_a (place_key(pa_c[1])),
        .raddr_b (place_key(pb_c[1])),
        .rdata_a (pl_a[1]),
        .rdata_b (pl_b[1])
    );

    // Same row shifts right, same column shifts down, otherwise swap columns.
    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            ra[k] = place_row(pl_a[k]);
            ca[k] = place_col(pl_a[k]);
            rb[k] = place_row(pl_b[k]);
            cb[k] = place_col(pl_b[k]);
            if (ra[k] == rb[k])
            begin
                qa[k] = cell_at(ra[k], coord_inc(ca[k]));
                qb[k] = cell_at(rb[k], coord_inc(cb[k]));
            end
            else if (ca[k] == cb[k])
            begin
                qa[k] = cell_at(coord_inc(ra[k]), ca[k]);
                qb[k] = cell_at(coord_inc(rb[k]), cb[k]);
            end
            else
            begin
                qa[k] = cell_at(ra[k], cb[k]);
                qb[k] = cell_at(rb[k], ca[k]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_v_reg   <= 1'b0;
            s3_np_reg  <= '0;
            s3_end_reg <= 1'b0;
        end
        else if (adv)
        begin
            s3_v_reg   <= s2_v_reg;
            s3_np_reg  <= s2_np_reg;
            s3_end_reg <= s2_end_reg;
        end
    end

    // Grid place to letter, one memory per pair.
    pfc_dpram #(
        .DEPTH (GRID_CELLS),
        .WIDTH ($bits(letter_t))
    ) u_grid_p0 (
        .clk     (clk),
        .we      (ks_wr.we),
        .waddr   (ks_wr.pos),
        .wdata   (ks_wr.letter),
        .re      (adv),
        .raddr_a (qa[0]),
        .raddr_b (qb[0]),
        .rdata_a (gl[0]),
        .rdata_b (gl[1])
    );

    pfc_dpram #(
        .DEPTH (GRID_CELLS),
        .WIDTH ($bits(letter_t))
    ) u_grid_p1 (
        .clk     (clk),
        .we      (ks_wr.we),
        .waddr   (ks_wr.pos),
        .wdata   (ks_wr.letter),
        .re      (adv),
        .raddr_a (qa[1]),
        .raddr_b (qb[1]),
        .rdata_a (gl[2]),
        .rdata_b (gl[3])
    );

    // A message end with no letters to send still gives one empty word with the end mark.
    always_comb
    begin
        if (s3_np_reg == 2'd0)
            res_cnt = s3_end_reg ? PUSH_W'(1) : '0;
        else
            res_cnt = PUSH_W'({s3_np_reg, 1'b0});
        for (int k = 0; k < MAX_RES; k++)
        begin
            if (s3_np_reg == 2'd0)
            begin
                res[k] = '{cipher_char: '0, has_char: 1'b0, message_end: 1'b1};
            end
            else
            begin
                res[k].cipher_char = CHAR_BASE + 7'(gl[k]);
                res[k].has_char    = 1'b1;
                res[k].message_end = s3_end_reg && (PUSH_W'(k + 1) == res_cnt);
            end
        end
    end

    assign push_cnt = (s3_v_reg && adv) ? res_cnt : '0;

    pfc_out_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_out_fifo (
        .clk             (clk),
        .rst_n           (rst_n),
        .push_cnt        (push_cnt),
        .push_data       (res),
        .room            (adv),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .cipher_char     (cipher_char),
        .has_char        (has_char),
        .message_end_res (message_end_res)
    );

    a_build_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        ks_busy |-> !(s1_v_reg || s2_v_reg || s3_v_reg))
        else $error("grid rebuild overlaps words in flight");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_v_reg && adv && s1_end_reg) |=> (!held_v_reg && !prev_v_reg))
        else $error("message end did not clear the pairing state");

    a_fresh_grid: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !prev_v_reg) |-> (!dirty_reg && !ks_busy))
        else $error("message started on a stale grid");

endmodule

`default_nettype wire

### bench/playfair_checker.sv
`timescale 1ns / 1ps

module playfair_checker import pfc_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [7:0]  text_char,
    input  wire logic        message_end,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [6:0]  cipher_char,
    input  wire logic        has_char,
    input  wire logic        message_end_res,
    output int               mismatches,
    output int               pending_words
);

    logic [63:0] key_low;
    logic [63:0] key_high;
    logic [4:0]  key_len;

    letter_t grid_map [GRID_CELLS];
    place_t  place_of [ALPHA];
    letter_t held_letter;
    logic    held_valid;
    letter_t last_letter;
    logic    last_valid;

    result_t step_out [MAX_RES];
    int      step_n;
    result_t cipher_due [$];
    result_t next_due;

    function automatic int letter_code(input logic [7:0] b);
        int code;
        code = -1;
        if (b >= ASCII_UP_A && b <= ASCII_UP_Z)
            code = int'(b - ASCII_UP_A);
        else if (b >= ASCII_LO_A && b <= ASCII_LO_Z)
            code = int'(b - ASCII_LO_A);
        return code;
    endfunction

    // Key letters first, then the rest of the alphabet; J never gets a cell of its own.
    function automatic void rebuild_grid();
        logic [127:0] key_bits;
        bit           used [ALPHA];
        int           pos;
        int           n;
        int           code;
        int           i;
        key_bits = {key_high, key_low};
        for (i = 0; i < ALPHA; i++)
            used[i] = 1'b0;
        used[LETTER_J] = 1'b1;
        pos = 0;
        n = (int'(key_len) > KEY_CHARS_DEF) ? KEY_CHARS_DEF : int'(key_len);
        for (i = 0; i < n; i++)
        begin
            code = letter_code(key_bits[8*i +: 8]);
            if (code >= 0)
            begin
                if (code == LETTER_J)
                    code = LETTER_I;
                if (!used[code] && pos < GRID_CELLS)
                begin
                    used[code] = 1'b1;
                    grid_map[pos] = letter_t'(code);
                    pos++;
                end
            end
        end
        for (i = 0; i < ALPHA; i++)
        begin
            if (!used[i] && pos < GRID_CELLS)
            begin
                used[i] = 1'b1;
                grid_map[pos] = letter_t'(i);
                pos++;
            end
        end
        for (i = 0; i < GRID_CELLS; i++)
            place_of[grid_map[i]] = place_t'(i);
        place_of[LETTER_J] = place_of[LETTER_I];
    endfunction

    function automatic void add_letter(input letter_t l);
        step_out[step_n].cipher_char = CHAR_BASE + 7'(l);
        step_out[step_n].has_char    = 1'b1;
        step_out[step_n].message_end = 1'b0;
        step_n++;
    endfunction

    function automatic void encipher(input letter_t a, input letter_t b);
        int p1, p2, r1, c1, r2, c2, q1, q2;
        p1 = int'(place_of[a]);
        p2 = int'(place_of[b]);
        r1 = p1 / SIDE;
        c1 = p1 % SIDE;
        r2 = p2 / SIDE;
        c2 = p2 % SIDE;
        if (r1 == r2)
        begin
            q1 = r1 * SIDE + (c1 + 1) % SIDE;
            q2 = r2 * SIDE + (c2 + 1) % SIDE;
        end
        else if (c1 == c2)
        begin
            q1 = ((r1 + 1) % SIDE) * SIDE + c1;
            q2 = ((r2 + 1) % SIDE) * SIDE + c2;
        end
        else
        begin
            q1 = r1 * SIDE + c2;
            q2 = r2 * SIDE + c1;
        end
        add_letter(grid_map[q1]);
        add_letter(grid_map[q2]);
    endfunction

    function automatic void push_letter(input letter_t l);
        if (held_valid)
        begin
            encipher(held_letter, l);
            held_valid  = 1'b0;
            held_letter = '0;
        end
        else
        begin
            held_letter = l;
            held_valid  = 1'b1;
        end
    endfunction

    function automatic void predict_word(input logic [7:0] ch, input logic fin);
        int code;
        int k;
        step_n = 0;
        // The grid follows the key registers until the first letter of a message.
        if (!last_valid)
            rebuild_grid();
        code = letter_code(ch);
        if (code >= 0)
        begin
            if (last_valid && int'(last_letter) == code)
                push_letter(LETTER_X);
            push_letter(letter_t'(code));
            last_letter = letter_t'(code);
            last_valid  = 1'b1;
        end
        if (fin)
        begin
            if (held_valid)
                push_letter(LETTER_X);
            if (step_n == 0)
            begin
                step_out[0].cipher_char = '0;
                step_out[0].has_char    = 1'b0;
                step_out[0].message_end = 1'b1;
                step_n = 1;
            end
            else
                step_out[step_n - 1].message_end = 1'b1;
            held_letter = '0;
            held_valid  = 1'b0;
            last_letter = '0;
            last_valid  = 1'b0;
        end
        for (k = 0; k < step_n; k++)
            cipher_due.push_back(step_out[k]);
    endfunction

    task automatic report_mismatch(input string what, input logic [6:0] got,
                                   input logic [6:0] want);
        $display("MISMATCH at %0t: %s got %0h, expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low     = '0;
            key_high    = '0;
            key_len     = '0;
            held_letter = '0;
            held_valid  = 1'b0;
            last_letter = '0;
            last_valid  = 1'b0;
            cipher_due.delete();
            rebuild_grid();
            pending_words = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (cipher_due.size() == 0)
                    report_mismatch("result word with none due, cipher_char", cipher_char, '0);
                else
                begin
                    next_due = cipher_due.pop_front();
                    if (cipher_char !== next_due.cipher_char)
                        report_mismatch("cipher_char", cipher_char, next_due.cipher_char);
                    if (has_char !== next_due.has_char)
                        report_mismatch("has_char", 7'(has_char), 7'(next_due.has_char));
                    if (message_end_res !== next_due.message_end)
                        report_mismatch("message_end_res", 7'(message_end_res),
                                        7'(next_due.message_end));
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_KEY_LOW:  key_low  = cfg_data;
                    REG_KEY_HIGH: key_high = cfg_data;
                    REG_KEY_LEN:  key_len  = cfg_data[4:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                predict_word(text_char, message_end);
            pending_words = cipher_due.size();
        end
    end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import pfc_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 12;
    localparam int PHASE_WORDS    = 37;
    localparam int DIRECTED_N     = 24;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_we      = 1'b0;
    logic [1:0]  cfg_index   = REG_KEY_LOW;
    logic [63:0] cfg_data    = '0;
    logic        in_valid    = 1'b0;
    logic [7:0]  text_char   = '0;
    logic        message_end = 1'b0;
    logic        out_stall   = 1'b0;

    wire logic       in_stall;
    wire logic       out_valid;
    wire logic [6:0] cipher_char;
    wire logic       has_char;
    wire logic       message_end_res;

    int mismatches;
    int pending_words;
    int sender_pct   = 0;
    int recv_pct     = 0;
    bit hold_off     = 1'b0;
    int quiet_cycles = 0;
    int phase_words  = 0;

    // {message end, byte}: doubled letters, dropped bytes at the letter range borders,
    // J next to I, a case-folded double across a pair, a lone X, and an end with
    // nothing left to send.
    logic [8:0] directed_words [DIRECTED_N] = '{
        {1'b0, "H"}, {1'b0, "e"}, {1'b0, "l"}, {1'b0, "l"}, {1'b1, "o"},
        {1'b0, 8'h00}, {1'b0, 8'hFF}, {1'b0, 8'h40}, {1'b0, 8'h5B},
        {1'b0, 8'h60}, {1'b0, 8'h7B}, {1'b1, 8'hC1},
        {1'b0, "J"}, {1'b0, "i"}, {1'b0, "z"}, {1'b0, "Z"}, {1'b1, "a"},
        {1'b1, "X"},
        {1'b0, "A"}, {1'b0, "F"}, {1'b1, "B"},
        {1'b0, "P"}, {1'b0, "Q"}, {1'b1, "."}
    };

    always #10 clk = ~clk;

    playfair_digraph_cipher_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .text_char       (text_char),
        .message_end     (message_end),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .cipher_char     (cipher_char),
        .has_char        (has_char),
        .message_end_res (message_end_res)
    );

    playfair_checker cipher_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .text_char       (text_char),
        .message_end     (message_end),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .cipher_char     (cipher_char),
        .has_char        (has_char),
        .message_end_res (message_end_res),
        .mismatches      (mismatches),
        .pending_words   (pending_words)
    );

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Result side. Decisions are taken at the falling edge so that the stimulus
    // process can change the mode at a rising edge without a race.
    initial
    begin : receiver
        bit hold_now;
        bit stall_now;
        forever
        begin
            @(negedge clk);
            hold_now  = hold_off;
            stall_now = ($urandom_range(99) < recv_pct);
            @(posedge clk);
            if (hold_now)
            begin
                hold_off = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_stall <= stall_now;
        end
    end

    function automatic logic [127:0] pack_key(input string s);
        logic [127:0] k;
        int           i;
        k = '0;
        for (i = 0; i < s.len() && i < 16; i++)
            k[8*i +: 8] = s[i];
        return k;
    endfunction

    function automatic logic [127:0] random_key();
        logic [127:0] k;
        int           i;
        for (i = 0; i < 16; i++)
        begin
            if ($urandom_range(99) < 75)
                k[8*i +: 8] = 8'(ASCII_UP_A + $urandom_range(25))
                              | ($urandom_range(1) ? 8'h20 : 8'h00);
            else
                k[8*i +: 8] = 8'($urandom_range(255));
        end
        return k;
    endfunction

    // Called at a rising edge; returns at the edge that accepted the word.
    task automatic send_word(input logic [7:0] ch, input logic fin);
        bit took;
        while ($urandom_range(99) < sender_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        text_char   <= ch;
        message_end <= fin;
        do
        begin
            @(negedge clk);
            took = !in_stall;
            @(posedge clk);
        end
        while (!took);
        if (fin || (ch >= ASCII_UP_A && ch <= ASCII_UP_Z)
                || (ch >= ASCII_LO_A && ch <= ASCII_LO_Z))
            phase_words++;
    endtask

    // Mostly letters with doubles, X, I and J mixed in; some noise bytes and a few
    // messages that are a single byte with the end mark.
    task automatic send_message();
        int         len;
        int         k;
        int         r;
        logic [7:0] ch;
        logic [7:0] prev;
        prev = "A";
        if ($urandom_range(99) < 8)
            send_word(8'($urandom_range(255)), 1'b1);
        else
        begin
            len = ($urandom_range(99) < 90) ? $urandom_range(1, 8) : $urandom_range(9, 20);
            for (k = 0; k < len; k++)
            begin
                r = $urandom_range(99);
                if (r < 20)
                    ch = prev ^ ($urandom_range(1) ? 8'h20 : 8'h00);
                else if (r < 65)
                    ch = 8'(ASCII_UP_A + $urandom_range(25))
                         | ($urandom_range(1) ? 8'h20 : 8'h00);
                else if (r < 75)
                    ch = $urandom_range(1) ? "X" : "x";
                else if (r < 85)
                    ch = ($urandom_range(1) ? "I" : "J") | ($urandom_range(1) ? 8'h20 : 8'h00);
                else
                    ch = 8'($urandom_range(255));
                if ((ch >= ASCII_UP_A && ch <= ASCII_UP_Z)
                        || (ch >= ASCII_LO_A && ch <= ASCII_LO_Z))
                    prev = ch;
                send_word(ch, k == len - 1);
            end
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_words != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_key(input logic [127:0] k, input logic [4:0] len);
        cfg_we    <= 1'b1;
        cfg_index <= REG_KEY_LOW;
        cfg_data  <= k[63:0];
        @(posedge clk);
        cfg_index <= REG_KEY_HIGH;
        cfg_data  <= k[127:64];
        @(posedge clk);
        cfg_index <= REG_KEY_LEN;
        cfg_data  <= {59'd0, len};
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin : stimulus
        int i;
        int p;
        bit pressure_done;
        pressure_done = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIRECTED_N; i++)
            send_word(directed_words[i][7:0], directed_words[i][8]);

        for (p = 1; p < 8; p++)
        begin
            settle();
            case (p)
                1: set_key(pack_key("PlayfairExample"), 5'd15);
                2: set_key({64'hFFFF_FFFF_FFFF_FFFF, 64'd0}, 5'd31);
                3: set_key(random_key(), 5'($urandom_range(16)));
                4: set_key(random_key(), 5'd16);
                5: set_key({64'd0, 64'hFFFF_FFFF_FFFF_FFFF}, 5'd0);
                6: set_key(pack_key("jJiIxXzzZZaAqQ k"), 5'd16);
                default: set_key(random_key(), 5'($urandom_range(31, 17)));
            endcase
            case (p % 4)
                0:
                begin
                    sender_pct = 0;
                    recv_pct   = 0;
                end
                1:
                begin
                    sender_pct = 74;
                    recv_pct   = 0;
                end
                2:
                begin
                    sender_pct = 0;
                    recv_pct   = 74;
                end
                default:
                begin
                    sender_pct = 33;
                    recv_pct   = 33;
                end
            endcase
            phase_words = 0;
            while (phase_words < PHASE_WORDS)
            begin
                // The long hold-off lets the output FIFO fill so the input must stall.
                if (p == 4 && phase_words >= 10 && !pressure_done)
                begin
                    hold_off      = 1'b1;
                    pressure_done = 1'b1;
                end
                send_message();
            end
        end

        settle();
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
